>>> design/pcmapb_pkg.sv
// Shared types and constants for the PCM playback device.
package pcmapb_pkg;

   // Default geometry of the sample buffers
   localparam int BUFFER_DEPTH_DEF = 4096;
   localparam int PLAY_WORDS_DEF   = 2048;

   // Stream payload widths
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 64;
   localparam int OP_W       = 2;
   localparam int SAMPLE_W   = 16;

   // Operation codes carried in req_tuser
   localparam logic [OP_W-1:0] OP_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

   // Register window: word index 8 is the play position
   localparam logic [7:0] CTRL_POS_INDEX = 8'd8;

   // Sample format taken from control word 0
   typedef struct packed {
      logic wide;   // 16-bit samples
      logic coded;  // signed (16-bit) or log-compressed (8-bit)
   } fmt_type;

endpackage

>>> design/pcmapb_fetch.sv
// Turns one buffer word into a 16-bit signed sample for the selected format.
module pcmapb_fetch (
   input  logic [31:0]                          word,
   input  pcmapb_pkg::fmt_type                  fmt,
   input  logic [1:0]                           pos_lo,
   output logic signed [pcmapb_pkg::SAMPLE_W-1:0] sample
);
   import pcmapb_pkg::*;

   logic [15:0] half;
   logic [7:0]  samp_byte;
   logic [15:0] mag;

   // Half-word and byte selection by play position
   always_comb begin
      half = pos_lo[0] ? word[31:16] : word[15:0];
      case (pos_lo)
         2'd0: samp_byte = word[7:0];
         2'd1: samp_byte = word[15:8];
         2'd2: samp_byte = word[23:16];
         2'd3: samp_byte = word[31:24];
         default: samp_byte = word[7:0];
      endcase
   end

   // Log decode: sign, 3-bit exponent, 4-bit mantissa
   always_comb begin
      if (samp_byte[6:4] != 3'd0) begin
         mag = 16'({1'b1, samp_byte[3:0]}) << (4'(samp_byte[6:4]) + 4'd3);
      end else begin
         mag = {8'h00, samp_byte[3:0], 4'h0};
      end
   end

   // Format select; offset binary is a flip of the top bit
   always_comb begin
      if (fmt.wide) begin
         sample = fmt.coded ? half : (half ^ 16'h8000);
      end else if (fmt.coded) begin
         sample = samp_byte[7] ? 16'(~mag + 16'd1) : mag;
      end else begin
         sample = {~samp_byte[7], samp_byte[6:0], 8'h00};
      end
   end

endmodule

>>> design/pcm_audio_playback_device.sv
// Stereo PCM playback device: sample buffers, control words, tick engine.
//
// Each request beat is a bus dword read or write into the left/right sample
// buffers, the eight control words or the play position, or a sample tick that
// returns one left/right sample pair and advances the play position by the
// elapsed microseconds divided by the sample period. Every request produces
// exactly one response beat. A bus access is accepted together with its
// buffer access and its response is loaded in ST_FINISH; an enabled tick
// reads both buffers and runs the first radix-4 step of the period divider
// on accept, two more divider steps follow in ST_DIV, and ST_FINISH loads
// the response and updates position and remainder. One request is worked on
// at a time; a new one is taken while the previous response still waits in
// the output register. Buffer contents are undefined until written; no
// clearing pass runs after reset.
module pcm_audio_playback_device #(
   parameter int BUFFER_DEPTH = pcmapb_pkg::BUFFER_DEPTH_DEF,
   parameter int PLAY_WORDS   = pcmapb_pkg::PLAY_WORDS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // byte_offset[15:0], write_data[47:16], elapsed_us[55:48]
   input  logic [pcmapb_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation[1:0]
   input  logic [pcmapb_pkg::OP_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // read_data[31:0], left_sample[47:32], right_sample[63:48]
   output logic [pcmapb_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import pcmapb_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam logic [15:0] PlayMask = 16'(PLAY_WORDS - 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIV    = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   typedef struct packed {
      logic [1:0] q;
      logic [8:0] r;
   } divstep_type;

   // Sample period in microseconds from the rate code
   function automatic logic [6:0] period_of(input logic [3:0] rate);
      logic [6:0] p;
      case (rate)
         4'd0: p = 7'd125;
         4'd1: p = 7'd91;
         4'd2: p = 7'd64;
         4'd3: p = 7'd45;
         4'd4: p = 7'd32;
         4'd5: p = 7'd23;
         4'd6: p = 7'd15;
         4'd7: p = 7'd11;
         4'd9: p = 7'd21;
         default: p = 7'd10;
      endcase
      return p;
   endfunction

   // One radix-4 restoring step against the period shifted by sh
   function automatic divstep_type div_step(input logic [8:0] r, input logic [6:0] per,
                                            input logic [2:0] sh);
      logic [12:0] d1;
      logic [12:0] d2;
      logic [12:0] d3;
      logic [12:0] rx;
      divstep_type res;
      d1 = 13'(per) << sh;
      d2 = d1 << 1;
      d3 = d1 + d2;
      rx = 13'(r);
      if (rx >= d3) begin
         res.q = 2'd3;
         res.r = 9'(rx - d3);
      end else if (rx >= d2) begin
         res.q = 2'd2;
         res.r = 9'(rx - d2);
      end else if (rx >= d1) begin
         res.q = 2'd1;
         res.r = 9'(rx - d1);
      end else begin
         res.q = 2'd0;
         res.r = r;
      end
      return res;
   endfunction

   // Request fields
   logic [1:0]  req_op;
   logic [15:0] req_offset;
   logic [31:0] req_wdata;
   logic [7:0]  req_elapsed;

   assign req_op      = req_tuser;
   assign req_offset  = req_tdata[15:0];
   assign req_wdata   = req_tdata[47:16];
   assign req_elapsed = req_tdata[55:48];

   // State
   state_type   state_ff, state_in;
   logic [31:0] control_ff [8];
   logic [12:0] pos_ff, pos_in;
   logic [6:0]  rem_ff, rem_in;
   logic        step_ff, step_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Per-request payload
   logic [6:0]  per_ff;
   logic [8:0]  div_r_ff;
   logic [5:0]  quot_ff;
   logic [31:0] read_ff;
   logic        rd_left_ff;
   logic        rd_right_ff;
   logic        tick_ff;

   // Sample buffers
   logic [31:0] left_buf_ff  [BUFFER_DEPTH];
   logic [31:0] right_buf_ff [BUFFER_DEPTH];
   logic [31:0] left_q_ff;
   logic [31:0] right_q_ff;

   // Decode
   logic        accept;
   logic        in_ctrl, in_left, in_right;
   logic [7:0]  ctrl_idx;
   logic        is_cr, is_pos;
   logic [31:0] cr0;
   logic        tick_en;
   fmt_type     fmt;
   logic [15:0] bus_word, play_word, play_masked;
   logic [AW-1:0] buf_idx;
   logic        left_we, right_we, left_re, right_re;
   logic [31:0] reg_rdata;
   logic [6:0]  period;
   logic [8:0]  total;
   divstep_type st_first, st_next;
   logic        out_free, load;
   logic signed [SAMPLE_W-1:0] left_s, right_raw, right_s;
   logic [31:0] rdata_sel;

   assign accept     = req_tvalid & req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign in_ctrl    = (req_offset[15:12] == 4'hF);
   assign in_left    = (req_offset[15:14] == 2'b00);
   assign in_right   = (req_offset[15:14] == 2'b01);
   assign ctrl_idx   = req_offset[9:2];
   assign is_cr      = (ctrl_idx[7:3] == 5'd0);
   assign is_pos     = (ctrl_idx == CTRL_POS_INDEX);
   assign cr0        = control_ff[0];
   assign fmt.wide   = cr0[1];
   assign fmt.coded  = cr0[0];
   assign tick_en    = (req_op == OP_TICK) && (cr0[3:2] != 2'b00);

   // Buffer addressing: bus word or play word
   assign bus_word    = {4'h0, req_offset[13:2]};
   assign play_word   = cr0[1] ? {4'h0, pos_ff[12:1]} : {5'h00, pos_ff[12:2]};
   assign play_masked = play_word & PlayMask;
   assign buf_idx     = (req_op == OP_TICK) ? play_masked[AW-1:0] : bus_word[AW-1:0];

   assign left_we  = accept && (req_op == OP_WRITE) && in_left;
   assign right_we = accept && (req_op == OP_WRITE) && in_right;
   assign left_re  = accept && (((req_op == OP_READ) && in_left) || tick_en);
   assign right_re = accept && (((req_op == OP_READ) && in_right) || tick_en);

   // Buffer memories, registered read
   always_ff @(posedge clock) begin
      if (left_we) begin
         left_buf_ff[buf_idx] <= req_wdata;
      end
      if (left_re) begin
         left_q_ff <= left_buf_ff[buf_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (right_we) begin
         right_buf_ff[buf_idx] <= req_wdata;
      end
      if (right_re) begin
         right_q_ff <= right_buf_ff[buf_idx];
      end
   end

   // Register window read
   always_comb begin
      reg_rdata = 32'd0;
      if ((req_op == OP_READ) && in_ctrl) begin
         if (is_cr) begin
            reg_rdata = control_ff[ctrl_idx[2:0]];
         end else if (is_pos) begin
            reg_rdata = 32'(pos_ff);
         end
      end
   end

   // Period divider steps
   assign period   = period_of(cr0[7:4]);
   assign total    = 9'(rem_ff) + 9'(req_elapsed);
   assign st_first = div_step(total, period, 3'd4);
   assign st_next  = div_step(div_r_ff, per_ff, step_ff ? 3'd0 : 3'd2);

   // Sample decode
   pcmapb_fetch u_fetch_left (
      .word   (left_q_ff),
      .fmt    (fmt),
      .pos_lo (pos_ff[1:0]),
      .sample (left_s)
   );

   pcmapb_fetch u_fetch_right (
      .word   (right_q_ff),
      .fmt    (fmt),
      .pos_lo (pos_ff[1:0]),
      .sample (right_raw)
   );

   assign right_s   = cr0[2] ? right_raw : left_s;
   assign rdata_sel = rd_left_ff ? left_q_ff : (rd_right_ff ? right_q_ff : read_ff);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign load      = (state_ff == ST_FINISH) && out_free;

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            step_in = 1'b0;
            if (accept) begin
               state_in = tick_en ? ST_DIV : ST_FINISH;
            end
         end
         ST_DIV: begin
            step_in = ~step_ff;
            if (step_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (load) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (tick_ff) begin
                  rsp_data_in = {right_s, left_s, 32'd0};
                  pos_in      = pos_ff + 13'(quot_ff);
                  rem_in      = div_r_ff[6:0];
               end else begin
                  rsp_data_in = {32'd0, rdata_sel};
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= 13'd0;
         rem_ff       <= 7'd0;
         step_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            control_ff[i] <= 32'd0;
         end
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rem_ff       <= rem_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept && (req_op == OP_WRITE) && in_ctrl && is_cr) begin
            control_ff[ctrl_idx[2:0]] <= req_wdata;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         per_ff      <= period;
         div_r_ff    <= st_first.r;
         quot_ff     <= {st_first.q, 4'h0};
         read_ff     <= reg_rdata;
         rd_left_ff  <= (req_op == OP_READ) && in_left;
         rd_right_ff <= (req_op == OP_READ) && in_right;
         tick_ff     <= tick_en;
      end else if (state_ff == ST_DIV) begin
         div_r_ff <= st_next.r;
         quot_ff  <= step_ff ? {quot_ff[5:2], st_next.q} : {quot_ff[5:4], st_next.q, 2'b00};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
